// ----- design/wpa_pkg.sv -----
// wpa_pkg: shared types, codes and constants of the windowed period averager
// used by the channel interfaces, the controller, the datapath and the top level
`default_nettype none

package wpa_pkg;

   // default geometry of the sub-accumulator ring
   localparam int DEF_SLOT_BITS = 3;
   localparam int DEF_ACC_WIDTH = 16;

   // field widths of the channels and the csr port
   localparam int CMD_W      = 2;
   localparam int PERIOD_W   = 32;
   localparam int STATUS_W   = 2;
   localparam int MEAN_W     = 16;
   localparam int OUTCOME_W  = 3;
   localparam int SHIFT_W    = 3;
   localparam int TIMER_W    = 8;
   localparam int WIN_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [MEAN_W-1:0]  MEAN_MAX  = 16'hFFFF;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX = 3'h7;

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE     = 2'd0,
      CMD_TICK       = 2'd1,
      CMD_ACK        = 2'd2,
      CMD_CHAN_RESET = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 2'd0,
      STS_NOT_READY = 2'd1,
      STS_RANGE     = 2'd2,
      STS_FAULT     = 2'd3
   } status_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_NONE      = 3'd0,
      OUT_ACCUM     = 3'd1,
      OUT_WINDOW    = 3'd2,
      OUT_TOO_LARGE = 3'd3,
      OUT_IGNORED   = 3'd4
   } outcome_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_SHIFT    = 3'd0,
      CSR_TIMEOUT_TICKS   = 3'd1,
      CSR_MIN_PERIOD      = 3'd2,
      CSR_MAX_PERIOD      = 3'd3,
      CSR_SHIFT_AFTER_SUM = 3'd4,
      CSR_LIMIT_SIXTEEN   = 3'd5,
      CSR_BYPASS          = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_SAMPLE_ADD,
      FSM_SUM,
      FSM_MEAN,
      FSM_TICK_END,
      FSM_FINISH
   } fsm_state_type;

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic exec;
      logic acc_write;
      logic sum_step;
      logic publish;
      logic close_tick;
      logic load_out;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      cmd_type cmd;
      logic    accumulate;
      logic    advance;
      logic    ring_next;
      logic    sum_done;
   } ctl_stat_type;

endpackage

`default_nettype wire

// ----- design/wpa_if.sv -----
// wpa_req_if and wpa_rsp_if: valid/ready channels of the period averager
// depends on wpa_pkg for the field widths
`default_nettype none

interface wpa_req_if;
   import wpa_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [PERIOD_W-1:0] period;
   logic                capture_valid;

   modport source (output valid, command, period, capture_valid, input ready);
   modport sink   (input valid, command, period, capture_valid, output ready);
endinterface

interface wpa_rsp_if;
   import wpa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [MEAN_W-1:0]    mean_value;
   logic [OUTCOME_W-1:0] sample_outcome;
   logic                 running;
   logic                 fault;

   modport source (output valid, status, mean_value, sample_outcome, running, fault,
                   input ready);
   modport sink   (input valid, status, mean_value, sample_outcome, running, fault,
                   output ready);
endinterface

`default_nettype wire

// ----- design/wpa_ctrl.sv -----
// wpa_ctrl: sequencing state machine of the period averager
// depends on wpa_pkg; drives wpa_datapath through ctl_cmd_type
`default_nettype none

module wpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  wpa_pkg::ctl_stat_type stat,
   output wpa_pkg::ctl_cmd_type  ctl
);
   import wpa_pkg::*;

   fsm_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   // output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) state_in = FSM_EXEC;
         end
         FSM_EXEC: begin
            unique case (stat.cmd)
               CMD_SAMPLE: state_in = stat.accumulate ? FSM_SAMPLE_ADD : FSM_FINISH;
               CMD_TICK: begin
                  if (!stat.advance) state_in = FSM_FINISH;
                  else if (stat.ring_next) state_in = FSM_SUM;
                  else state_in = FSM_TICK_END;
               end
               CMD_ACK, CMD_CHAN_RESET: state_in = FSM_FINISH;
            endcase
         end
         FSM_SAMPLE_ADD: state_in = FSM_FINISH;
         FSM_SUM: begin
            if (stat.sum_done) state_in = FSM_MEAN;
         end
         FSM_MEAN:     state_in = FSM_FINISH;
         FSM_TICK_END: state_in = FSM_FINISH;
         FSM_FINISH: begin
            if (out_free) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_ready     = 1'b1;
            ctl.load_item = req_valid;
         end
         FSM_EXEC:       ctl.exec = 1'b1;
         FSM_SAMPLE_ADD: ctl.acc_write = 1'b1;
         FSM_SUM:        ctl.sum_step = 1'b1;
         FSM_MEAN: begin
            ctl.publish    = 1'b1;
            ctl.close_tick = 1'b1;
         end
         FSM_TICK_END:   ctl.close_tick = 1'b1;
         FSM_FINISH:     ctl.load_out = out_free;
         default: ;
      endcase
   end

   always_comb begin
      if (ctl.load_out) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- design/wpa_datapath.sv -----
// wpa_datapath: csr registers, sub-accumulator memory, slot counters,
// summing walk and result register; depends on wpa_pkg
`default_nettype none

module wpa_datapath #(
   parameter int SLOT_BITS = wpa_pkg::DEF_SLOT_BITS,
   parameter int ACC_WIDTH = wpa_pkg::DEF_ACC_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [wpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wpa_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [wpa_pkg::CMD_W-1:0]         req_command,
   input  logic [wpa_pkg::PERIOD_W-1:0]      req_period,
   input  logic                              req_capture_valid,
   input  wpa_pkg::ctl_cmd_type              ctl,
   output wpa_pkg::ctl_stat_type             stat,
   output logic [wpa_pkg::STATUS_W-1:0]      rsp_status,
   output logic [wpa_pkg::MEAN_W-1:0]        rsp_mean_value,
   output logic [wpa_pkg::OUTCOME_W-1:0]     rsp_sample_outcome,
   output logic                              rsp_running,
   output logic                              rsp_fault
);
   import wpa_pkg::*;

   localparam int IDX_W      = (SLOT_BITS > 0) ? SLOT_BITS : 1;
   localparam int SLOT_COUNT = 1 << SLOT_BITS;
   localparam int WALK_W     = SLOT_BITS + 1;
   localparam logic [PERIOD_W:0]    ACC_LIMIT = (PERIOD_W + 1)'((64'd1 << ACC_WIDTH) - 64'd1);
   localparam logic [IDX_W-1:0]     LAST_IDX  = IDX_W'(SLOT_COUNT - 1);
   localparam logic [WALK_W-1:0]    WALK_END  = WALK_W'(SLOT_COUNT);
   localparam logic [ACC_WIDTH-1:0] MEAN_LIM  = ACC_WIDTH'(MEAN_MAX);

   // csr registers
   logic [SHIFT_W-1:0] shift_ff;
   logic [TIMER_W-1:0] timeout_ff;
   logic [WIN_W-1:0]   min_ff, max_ff;
   logic               after_sum_ff, limit_ff, bypass_ff;

   // latched item
   cmd_type             cmd_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic                cvalid_ff;

   // channel state
   logic [IDX_W-1:0]      slot_idx_ff, slot_idx_in;
   logic [7:0]            left_ff, left_in;
   logic [TIMER_W-1:0]    timer_ff, timer_in;
   logic [MEAN_W-1:0]     held_ff, held_in;
   logic                  cap_en_ff, cap_en_in;
   logic                  block_ready_ff, block_ready_in;
   logic                  ring_ff, ring_in;
   logic                  first_done_ff, first_done_in;
   logic                  fresh_ff, fresh_in;
   logic                  ovf_ff, ovf_in;
   logic                  fault_ff, fault_in;
   logic [SLOT_COUNT-1:0] vld_ff, vld_in;
   logic [WALK_W-1:0]     walk_ff, walk_in;
   logic                  pend_ff, pend_in;
   logic [ACC_WIDTH-1:0]  total_ff, total_in;
   outcome_type           outcome_ff, outcome_in;

   // memory and its registered read port
   logic [ACC_WIDTH-1:0] acc_mem [SLOT_COUNT];
   logic [ACC_WIDTH-1:0] rd_mem_ff;
   logic                 rd_hit_ff;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [ACC_WIDTH-1:0] rd_word, sum_word, term, mean_full;

   // result register
   status_type          status_out_ff;
   logic [MEAN_W-1:0]   mean_out_ff;
   outcome_type         outcome_out_ff;
   logic                running_out_ff, fault_out_ff;

   logic [7:0]   low_ones, slot_samples;
   logic         shift_small, chan_reset, mean_ovf;
   outcome_type  outcome_next;
   status_type   status_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         timeout_ff   <= '0;
         min_ff       <= '0;
         max_ff       <= MEAN_MAX;
         after_sum_ff <= 1'b0;
         limit_ff     <= 1'b0;
         bypass_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SAMPLE_SHIFT:    shift_ff     <= csr_wdata[SHIFT_W-1:0] & SHIFT_MAX;
            CSR_TIMEOUT_TICKS:   timeout_ff   <= csr_wdata[TIMER_W-1:0];
            CSR_MIN_PERIOD:      min_ff       <= csr_wdata[WIN_W-1:0];
            CSR_MAX_PERIOD:      max_ff       <= csr_wdata[WIN_W-1:0];
            CSR_SHIFT_AFTER_SUM: after_sum_ff <= csr_wdata[0];
            CSR_LIMIT_SIXTEEN:   limit_ff     <= csr_wdata[0];
            CSR_BYPASS:          bypass_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_item) begin
         cmd_ff    <= cmd_type'(req_command);
         period_ff <= req_period;
         cvalid_ff <= req_capture_valid;
      end
   end

   // slot geometry for the current sample_shift
   assign low_ones     = (8'd1 << shift_ff) - 8'd1;
   assign shift_small  = {1'b0, shift_ff} < 4'(SLOT_BITS);
   assign slot_samples = shift_small ? 8'd1 : (8'd1 << (shift_ff - 3'(SLOT_BITS)));

   logic [IDX_W-1:0] reload_idx;
   assign reload_idx = shift_small ? low_ones[IDX_W-1:0] : LAST_IDX;

   always_comb begin
      if (!cvalid_ff || bypass_ff || !cap_en_ff || block_ready_ff)
         outcome_next = OUT_IGNORED;
      else if ({1'b0, period_ff} > ACC_LIMIT)
         outcome_next = OUT_TOO_LARGE;
      else if (period_ff < {16'd0, min_ff} || period_ff > {16'd0, max_ff})
         outcome_next = OUT_WINDOW;
      else
         outcome_next = OUT_ACCUM;
   end

   assign stat.cmd        = cmd_ff;
   assign stat.accumulate = (cmd_ff == CMD_SAMPLE) && (outcome_next == OUT_ACCUM);
   assign stat.advance    = !bypass_ff && block_ready_ff;
   assign stat.ring_next  = ring_ff || (slot_idx_ff == '0);
   assign stat.sum_done   = (walk_ff == WALK_END) && !pend_ff;

   // memory read: current slot on exec, walk position while summing
   assign rd_en   = ctl.exec || (ctl.sum_step && (walk_ff != WALK_END));
   assign rd_addr = ctl.sum_step ? walk_ff[IDX_W-1:0] : slot_idx_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_mem_ff <= acc_mem[rd_addr];
         rd_hit_ff <= vld_ff[rd_addr];
      end
      if (ctl.acc_write) acc_mem[slot_idx_ff] <= sum_word;
   end

   // an entry cleared since its last write reads as zero
   assign rd_word   = rd_hit_ff ? rd_mem_ff : '0;
   assign sum_word  = rd_word + ACC_WIDTH'(period_ff);
   assign term      = after_sum_ff ? rd_word : (rd_word >> shift_ff);
   assign mean_full = after_sum_ff ? (total_ff >> shift_ff) : total_ff;
   assign mean_ovf  = limit_ff && (mean_full > MEAN_LIM);

   always_comb begin
      slot_idx_in    = slot_idx_ff;
      left_in        = left_ff;
      timer_in       = timer_ff;
      held_in        = held_ff;
      cap_en_in      = cap_en_ff;
      block_ready_in = block_ready_ff;
      ring_in        = ring_ff;
      first_done_in  = first_done_ff;
      fresh_in       = fresh_ff;
      ovf_in         = ovf_ff;
      fault_in       = fault_ff;
      vld_in         = vld_ff;
      walk_in        = walk_ff;
      pend_in        = pend_ff;
      total_in       = total_ff;
      outcome_in     = outcome_ff;
      chan_reset     = 1'b0;

      if (ctl.exec) begin
         outcome_in = OUT_NONE;
         unique case (cmd_ff)
            CMD_SAMPLE: outcome_in = outcome_next;
            CMD_TICK: begin
               if (bypass_ff) begin
                  chan_reset = 1'b1;
                  fault_in   = 1'b0;
                  timer_in   = timeout_ff;
               end else begin
                  cap_en_in = 1'b1;
                  if (!block_ready_ff) begin
                     // data-less tick: run down the timeout
                     if (timeout_ff != '0) begin
                        if (timer_ff != '0) begin
                           timer_in = timer_ff - 8'd1;
                        end else begin
                           chan_reset = 1'b1;
                           fault_in   = 1'b1;
                           timer_in   = timeout_ff;
                        end
                     end
                  end else begin
                     left_in = slot_samples;
                     if (slot_idx_ff == '0) begin
                        slot_idx_in   = reload_idx;
                        first_done_in = 1'b1;
                        ring_in       = 1'b1;
                     end else begin
                        slot_idx_in = slot_idx_ff - IDX_W'(1);
                     end
                     walk_in  = '0;
                     pend_in  = 1'b0;
                     total_in = '0;
                  end
               end
            end
            CMD_ACK:        fresh_in = 1'b0;
            CMD_CHAN_RESET: chan_reset = 1'b1;
         endcase
      end

      if (ctl.acc_write) begin
         vld_in[slot_idx_ff] = 1'b1;
         left_in             = left_ff - 8'd1;
         if (left_ff == 8'd1) block_ready_in = 1'b1;
      end

      if (ctl.sum_step) begin
         if (walk_ff != WALK_END) walk_in = walk_ff + WALK_W'(1);
         pend_in = (walk_ff != WALK_END);
         if (pend_ff) total_in = total_ff + term;
      end

      if (ctl.publish) begin
         ovf_in = mean_ovf;
         if (!mean_ovf) held_in = mean_full[MEAN_W-1:0];
         fresh_in = 1'b1;
      end

      if (ctl.close_tick) begin
         vld_in[slot_idx_ff] = 1'b0;
         block_ready_in      = 1'b0;
         fault_in            = 1'b0;
         timer_in            = timeout_ff;
      end

      if (chan_reset) begin
         vld_in         = '0;
         ring_in        = 1'b0;
         block_ready_in = 1'b0;
         slot_idx_in    = reload_idx;
         left_in        = slot_samples;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_idx_ff    <= '0;
         left_ff        <= 8'd1;
         timer_ff       <= '0;
         held_ff        <= '0;
         cap_en_ff      <= 1'b0;
         block_ready_ff <= 1'b0;
         ring_ff        <= 1'b0;
         first_done_ff  <= 1'b0;
         fresh_ff       <= 1'b0;
         ovf_ff         <= 1'b0;
         fault_ff       <= 1'b0;
         vld_ff         <= '0;
         walk_ff        <= '0;
         pend_ff        <= 1'b0;
         outcome_ff     <= OUT_NONE;
      end else begin
         slot_idx_ff    <= slot_idx_in;
         left_ff        <= left_in;
         timer_ff       <= timer_in;
         held_ff        <= held_in;
         cap_en_ff      <= cap_en_in;
         block_ready_ff <= block_ready_in;
         ring_ff        <= ring_in;
         first_done_ff  <= first_done_in;
         fresh_ff       <= fresh_in;
         ovf_ff         <= ovf_in;
         fault_ff       <= fault_in;
         vld_ff         <= vld_in;
         walk_ff        <= walk_in;
         pend_ff        <= pend_in;
         outcome_ff     <= outcome_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
   end

   always_comb begin
      if (bypass_ff) status_now = STS_OK;
      else if (fault_ff) status_now = STS_FAULT;
      else if (ovf_ff) status_now = STS_RANGE;
      else if (!ring_ff || !fresh_ff) status_now = STS_NOT_READY;
      else status_now = STS_OK;
   end

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         status_out_ff  <= status_now;
         mean_out_ff    <= held_ff;
         outcome_out_ff <= outcome_ff;
         running_out_ff <= first_done_ff;
         fault_out_ff   <= fault_ff;
      end
   end

   assign rsp_status         = status_out_ff;
   assign rsp_mean_value     = mean_out_ff;
   assign rsp_sample_outcome = outcome_out_ff;
   assign rsp_running        = running_out_ff;
   assign rsp_fault          = fault_out_ff;

endmodule

`default_nettype wire

// ----- design/windowed_period_average.sv -----
// windowed_period_average: top level of the pressure-sensor period averager
// depends on wpa_pkg, wpa_if, wpa_ctrl and wpa_datapath
//
//  port group   dir   handshake         carries
//  req_ch       in    valid / ready     command, period, capture_valid
//  rsp_ch       out   valid / ready     status, mean_value, sample_outcome, running, fault
//  csr_*        in    csr_we            register index and write data
//
// one item at a time: ack and channel reset go idle, exec, finish; a sample adds an
// add state when it accumulates; a tick that publishes a mean runs a summing walk of the
// single adder over the sub-accumulator memory (one read per cycle), then mean and finish
// a new item is taken while the previous result still waits in the output register
// synchronous reset clears the control state and the entry valid bits; the memory needs no clearing pass
`default_nettype none

module windowed_period_average #(
   parameter int SLOT_BITS = wpa_pkg::DEF_SLOT_BITS,
   parameter int ACC_WIDTH = wpa_pkg::DEF_ACC_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [wpa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wpa_pkg::CSR_DATA_W-1:0] csr_wdata,
   wpa_req_if.sink                        req_ch,
   wpa_rsp_if.source                      rsp_ch
);
   import wpa_pkg::*;

   ctl_cmd_type  ctl;
   ctl_stat_type stat;

   wpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   wpa_datapath #(
      .SLOT_BITS (SLOT_BITS),
      .ACC_WIDTH (ACC_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_command        (req_ch.command),
      .req_period         (req_ch.period),
      .req_capture_valid  (req_ch.capture_valid),
      .ctl                (ctl),
      .stat               (stat),
      .rsp_status         (rsp_ch.status),
      .rsp_mean_value     (rsp_ch.mean_value),
      .rsp_sample_outcome (rsp_ch.sample_outcome),
      .rsp_running        (rsp_ch.running),
      .rsp_fault          (rsp_ch.fault)
   );

endmodule

`default_nettype wire

// ----- tb/tb_windowed_period_average.sv -----
`timescale 1ns / 100ps
// tb_windowed_period_average: self-checking testbench of the windowed period averager
// depends on wpa_pkg, wpa_req_if / wpa_rsp_if and windowed_period_average; a directed
// table runs first, then random phases; each result checked vs typed row or predictor

module tb_windowed_period_average;
   import wpa_pkg::*;

   localparam int CYCLE_LIMIT = 400_000;
   localparam int SETTLE      = 16;
   localparam int HOLD_AT     = 520;    // results seen before the long sink hold-off
   localparam int HOLD_LEN    = 300;
   localparam int SLOTS_LOG2  = DEF_SLOT_BITS;

   typedef struct packed {
      status_type  status;
      logic [15:0] mean;
      outcome_type outcome;
      logic        running;
      logic        fault;
   } reply_type;

   typedef struct packed {
      bit            is_write;
      csr_index_type reg_idx;
      logic [15:0]   reg_val;
      cmd_type       cmd;
      logic [31:0]   period;
      logic          cap_ok;
      bit            typed;
      reply_type     want;
   } step_type;

   localparam reply_type NO_WANT = '{STS_OK, 16'h0000, OUT_NONE, 1'b0, 1'b0};

   function automatic step_type item_row(cmd_type c, logic [31:0] p, logic ok);
      step_type s;
      s = '0;
      s.cmd = c;
      s.period = p;
      s.cap_ok = ok;
      return s;
   endfunction

   function automatic step_type typed_row(cmd_type c, logic [31:0] p, logic ok,
                                          status_type st, outcome_type oc);
      step_type s;
      s = item_row(c, p, ok);
      s.typed = 1'b1;
      s.want = '{st, 16'h0000, oc, 1'b0, 1'b0};
      return s;
   endfunction

   function automatic step_type reg_row(csr_index_type idx, logic [15:0] val);
      step_type s;
      s = '0;
      s.is_write = 1'b1;
      s.reg_idx = idx;
      s.reg_val = val;
      return s;
   endfunction

   localparam int SCRIPT_LEN = 36;
   localparam step_type SCRIPT [SCRIPT_LEN] = '{
      // capture stays off until the first tick
      typed_row(CMD_SAMPLE, 32'd5, 1'b1, STS_NOT_READY, OUT_IGNORED),
      typed_row(CMD_ACK, 32'd0, 1'b0, STS_NOT_READY, OUT_NONE),
      typed_row(CMD_TICK, 32'd0, 1'b1, STS_NOT_READY, OUT_NONE),
      typed_row(CMD_SAMPLE, 32'hFFFF_FFFF, 1'b1, STS_NOT_READY, OUT_TOO_LARGE),
      typed_row(CMD_SAMPLE, 32'h0001_0000, 1'b1, STS_NOT_READY, OUT_TOO_LARGE),
      typed_row(CMD_SAMPLE, 32'd100, 1'b0, STS_NOT_READY, OUT_IGNORED),
      item_row(CMD_SAMPLE, 32'h0000_FFFF, 1'b1),
      item_row(CMD_SAMPLE, 32'd7, 1'b1),          // ignored while the block waits
      item_row(CMD_TICK, 32'd0, 1'b1),
      item_row(CMD_ACK, 32'd0, 1'b1),
      item_row(CMD_SAMPLE, 32'd0, 1'b1),
      item_row(CMD_TICK, 32'd0, 1'b1),
      item_row(CMD_CHAN_RESET, 32'd0, 1'b1),
      reg_row(CSR_MIN_PERIOD, 16'd10),
      reg_row(CSR_MAX_PERIOD, 16'd20),
      item_row(CMD_SAMPLE, 32'd9, 1'b1),
      item_row(CMD_SAMPLE, 32'd21, 1'b1),
      item_row(CMD_SAMPLE, 32'd10, 1'b1),
      item_row(CMD_SAMPLE, 32'd20, 1'b1),
      reg_row(CSR_TIMEOUT_TICKS, 16'd2),
      item_row(CMD_TICK, 32'd0, 1'b1),
      item_row(CMD_TICK, 32'd0, 1'b1),
      item_row(CMD_TICK, 32'd0, 1'b1),
      item_row(CMD_TICK, 32'd0, 1'b1),            // timer ran out: fault
      reg_row(CSR_BYPASS, 16'd1),
      item_row(CMD_SAMPLE, 32'd15, 1'b1),
      item_row(CMD_TICK, 32'd0, 1'b1),
      reg_row(CSR_BYPASS, 16'd0),
      reg_row(CSR_SAMPLE_SHIFT, 16'(SHIFT_MAX)),
      reg_row(CSR_SHIFT_AFTER_SUM, 16'd1),
      reg_row(CSR_LIMIT_SIXTEEN, 16'd1),
      reg_row(CSR_TIMEOUT_TICKS, 16'd0),
      reg_row(CSR_MIN_PERIOD, 16'h0000),
      reg_row(CSR_MAX_PERIOD, 16'hFFFF),
      item_row(CMD_SAMPLE, 32'h0000_8000, 1'b1),
      item_row(CMD_TICK, 32'd0, 1'b1)
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   wpa_req_if req_ch ();
   wpa_rsp_if rsp_ch ();

   windowed_period_average dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   always #1 clock = ~clock;

   // predictor copy of the registers
   logic [2:0]  cfg_shift;
   logic [7:0]  cfg_timeout;
   logic [15:0] cfg_min;
   logic [15:0] cfg_max;
   logic        cfg_after;
   logic        cfg_limit;
   logic        cfg_bypass;

   // predictor copy of the channel state
   logic [15:0] acc_ring [8];
   logic [2:0]  slot_ptr;
   logic [7:0]  left_in_slot;
   logic [7:0]  timer;
   logic [15:0] mean_hold;
   logic        capture_on, block_full, ring_live, round_done;
   logic        mean_new, mean_over, fault_on;

   reply_type pending_replies [$];
   int        mismatches;
   int        results_seen;
   int        cycles;
   bit        no_idle;
   int        hold_left;
   bit        hold_done;

   function automatic logic [2:0] top_slot();
      if (cfg_shift < SLOTS_LOG2)
         return 3'((1 << cfg_shift) - 1);
      return 3'd7;
   endfunction

   function automatic logic [7:0] per_slot();
      if (cfg_shift < SLOTS_LOG2)
         return 8'd1;
      return 8'(1 << (cfg_shift - SLOTS_LOG2));
   endfunction

   function automatic void clear_channel();
      foreach (acc_ring[k])
         acc_ring[k] = 16'h0000;
      ring_live = 1'b0;
      block_full = 1'b0;
      slot_ptr = top_slot();
      left_in_slot = per_slot();
   endfunction

   function automatic void set_fault_state(logic on);
      fault_on = on;
      timer = cfg_timeout;
   endfunction

   function automatic void reset_averager();
      cfg_shift = 3'd0;
      cfg_timeout = 8'd0;
      cfg_min = 16'h0000;
      cfg_max = 16'hFFFF;
      cfg_after = 1'b0;
      cfg_limit = 1'b0;
      cfg_bypass = 1'b0;
      mean_hold = 16'h0000;
      capture_on = 1'b0;
      round_done = 1'b0;
      mean_new = 1'b0;
      mean_over = 1'b0;
      clear_channel();
      set_fault_state(1'b0);
   endfunction

   function automatic void publish_mean();
      logic [18:0] total;
      logic [15:0] folded;
      total = '0;
      for (int k = 0; k < 8; k++)
         total += cfg_after ? {3'b000, acc_ring[k]} : {3'b000, acc_ring[k] >> cfg_shift};
      folded = total[15:0];
      if (cfg_after)
         folded = folded >> cfg_shift;
      mean_over = cfg_limit && (folded > MEAN_MAX);
      if (!mean_over)
         mean_hold = folded;
      mean_new = 1'b1;
   endfunction

   function automatic reply_type average_step(cmd_type c, logic [31:0] p, logic ok);
      reply_type r;
      r = NO_WANT;
      case (c)
         CMD_SAMPLE: begin
            if (!ok || cfg_bypass || !capture_on || block_full)
               r.outcome = OUT_IGNORED;
            else if (p > 32'h0000_FFFF)
               r.outcome = OUT_TOO_LARGE;
            else if (p[15:0] < cfg_min || p[15:0] > cfg_max)
               r.outcome = OUT_WINDOW;
            else begin
               acc_ring[slot_ptr] = acc_ring[slot_ptr] + p[15:0];
               left_in_slot = left_in_slot - 8'd1;
               if (left_in_slot == 8'd0)
                  block_full = 1'b1;
               r.outcome = OUT_ACCUM;
            end
         end
         CMD_TICK: begin
            if (cfg_bypass) begin
               clear_channel();
               set_fault_state(1'b0);
            end else begin
               capture_on = 1'b1;
               if (!block_full) begin
                  if (cfg_timeout != 8'd0) begin
                     if (timer > 8'd0)
                        timer = timer - 8'd1;
                     else begin
                        clear_channel();
                        set_fault_state(1'b1);
                     end
                  end
               end else begin
                  left_in_slot = per_slot();
                  if (slot_ptr == 3'd0) begin
                     slot_ptr = top_slot();
                     round_done = 1'b1;
                     ring_live = 1'b1;
                  end else
                     slot_ptr = slot_ptr - 3'd1;
                  if (ring_live)
                     publish_mean();
                  acc_ring[slot_ptr] = 16'h0000;
                  block_full = 1'b0;
                  set_fault_state(1'b0);
               end
            end
         end
         CMD_ACK: mean_new = 1'b0;
         default: clear_channel();
      endcase
      if (cfg_bypass)
         r.status = STS_OK;
      else if (fault_on)
         r.status = STS_FAULT;
      else if (mean_over)
         r.status = STS_RANGE;
      else if (!ring_live || !mean_new)
         r.status = STS_NOT_READY;
      else
         r.status = STS_OK;
      r.mean = mean_hold;
      r.running = round_done;
      r.fault = fault_on;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("tb: %s mismatch on result %0d: got %0d, expected %0d",
               what, results_seen, got, want);
   endtask

   // one register write, with the enable dropped on the following edge
   task automatic write_reg(input csr_index_type idx, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SAMPLE_SHIFT:    cfg_shift = val[2:0];
         CSR_TIMEOUT_TICKS:   cfg_timeout = val[7:0];
         CSR_MIN_PERIOD:      cfg_min = val;
         CSR_MAX_PERIOD:      cfg_max = val;
         CSR_SHIFT_AFTER_SUM: cfg_after = val[0];
         CSR_LIMIT_SIXTEEN:   cfg_limit = val[0];
         CSR_BYPASS:          cfg_bypass = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // stop offering and wait until the block has answered everything
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic send_item(input cmd_type c, input logic [31:0] p, input logic ok,
                            input bit typed, input reply_type want);
      bit taken;
      reply_type predicted;
      while (!no_idle && $urandom_range(0, 99) < 32) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= c;
      req_ch.period <= p;
      req_ch.capture_valid <= ok;
      do begin
         @(negedge clock);
         taken = (req_ch.ready === 1'b1);
         if (taken) begin
            predicted = average_step(c, p, ok);
            pending_replies.push_back(typed ? want : predicted);
         end
         @(posedge clock);
      end while (!taken);
   endtask

   // result side: ready at random, or always while no_idle is set, with one long hold-off
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= HOLD_LEN;
         hold_done <= 1'b1;
      end else
         rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 32);
   end

   // a transfer completes at the next rising edge; both sides are stable here
   always @(negedge clock) begin : result_watch
      reply_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_replies.size() == 0)
            report_mismatch("unexpected result", 1, 0);
         else begin
            want = pending_replies.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch("status", rsp_ch.status, want.status);
            if (rsp_ch.mean_value !== want.mean)
               report_mismatch("mean_value", rsp_ch.mean_value, want.mean);
            if (rsp_ch.sample_outcome !== want.outcome)
               report_mismatch("sample_outcome", rsp_ch.sample_outcome, want.outcome);
            if (rsp_ch.running !== want.running)
               report_mismatch("running", rsp_ch.running, want.running);
            if (rsp_ch.fault !== want.fault)
               report_mismatch("fault", rsp_ch.fault, want.fault);
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      cmd_type     c;
      logic [31:0] p;
      logic        ok;
      int          r;
      int          items;
      logic [15:0] lo, hi;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_SAMPLE_SHIFT;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.command = CMD_SAMPLE;
      req_ch.period = '0;
      req_ch.capture_valid = 1'b0;
      rsp_ch.ready = 1'b0;
      mismatches = 0;
      results_seen = 0;
      cycles = 0;
      no_idle = 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      reset_averager();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (SCRIPT[i]) begin
         if (SCRIPT[i].is_write) begin
            drain();
            write_reg(SCRIPT[i].reg_idx, SCRIPT[i].reg_val);
         end else
            send_item(SCRIPT[i].cmd, SCRIPT[i].period, SCRIPT[i].cap_ok,
                      SCRIPT[i].typed, SCRIPT[i].want);
      end

      for (int phase = 0; phase < 9; phase++) begin
         drain();
         if (phase == 0) begin
            lo = 16'h0000;
            hi = 16'hFFFF;
         end else if (phase == 1) begin
            lo = 16'hFFFF;
            hi = 16'hFFFF;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               lo = 16'($urandom_range(0, 4000));
               hi = 16'($urandom_range(30000, 65535));
            end else if (r < 80) begin
               lo = 16'($urandom);
               hi = 16'($urandom);
            end else begin
               lo = 16'h0000;
               hi = 16'hFFFF;
            end
         end
         write_reg(CSR_MIN_PERIOD, lo);
         write_reg(CSR_MAX_PERIOD, hi);
         r = $urandom_range(0, 2);
         write_reg(CSR_SAMPLE_SHIFT, phase == 0 ? 16'(SHIFT_MAX) :
                   phase == 1 ? 16'd0 : 16'($urandom_range(0, 7)));
         write_reg(CSR_TIMEOUT_TICKS, phase == 0 ? 16'd255 : phase == 1 ? 16'd1 :
                   r == 0 ? 16'd0 : r == 1 ? 16'($urandom_range(1, 6)) : 16'd255);
         write_reg(CSR_SHIFT_AFTER_SUM, phase == 0 ? 16'd1 : phase == 1 ? 16'd0 :
                   16'($urandom_range(0, 1)));
         write_reg(CSR_LIMIT_SIXTEEN, phase == 0 ? 16'd1 : phase == 1 ? 16'd0 :
                   16'($urandom_range(0, 1)));
         write_reg(CSR_BYPASS, phase == 2 ? 16'd1 :
                   phase < 2 ? 16'd0 : 16'($urandom_range(0, 9) == 0));
         no_idle = (phase == 3);
         items = phase == 0 ? 250 : phase == 1 ? 80 : phase == 2 ? 30 : 90;

         for (int n = 0; n < items; n++) begin
            if ($urandom_range(0, 199) == 0)
               drain();
            if (block_full && !cfg_bypass && $urandom_range(0, 99) < 80)
               c = CMD_TICK;
            else begin
               r = $urandom_range(0, 99);
               if (r < 6)
                  c = CMD_ACK;
               else if (r < 9)
                  c = CMD_CHAN_RESET;
               else if (r < 18)
                  c = CMD_TICK;
               else
                  c = CMD_SAMPLE;
            end
            p = $urandom;
            if (c == CMD_SAMPLE) begin
               r = $urandom_range(0, 99);
               if (r < 70) begin
                  if (cfg_min <= cfg_max)
                     p = {16'h0000, cfg_min} + $urandom_range(0, int'(cfg_max) - int'(cfg_min));
                  else
                     p = $urandom_range(0, 65535);
               end else if (r < 78)
                  p = $urandom_range(0, 1) ? {16'h0000, cfg_min} - 32'd1
                                           : {16'h0000, cfg_max} + 32'd1;
               else if (r >= 88)
                  p = $urandom_range(0, 65535);
            end
            ok = ($urandom_range(0, 99) < 94);
            send_item(c, p, ok, 1'b0, NO_WANT);
         end
      end

      no_idle = 1'b0;
      drain();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
